// File: rtl/ttca_pkg.sv
// ----------------------------------------------------------------------------
// ttca_pkg
// Shared types and constants for the trade tick candle aggregator.
// ----------------------------------------------------------------------------
package ttca_pkg;

  localparam int INTERVAL_W = 17;
  localparam int PRICE_W    = 56;
  localparam int AMOUNT_W   = 56;
  localparam int WORD_W     = 64;
  localparam int INDEX_W    = 4;
  localparam int NUM_WORDS  = 15;
  localparam int NUM_BUCKETS = 5;

  localparam logic [INDEX_W-1:0] WORD_LAST = 4'd14;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 17'd60;

  // Bucket limits in 1e-8 units.
  localparam logic [AMOUNT_W-1:0] LIMIT_1K   = 56'd100000000000;
  localparam logic [AMOUNT_W-1:0] LIMIT_10K  = 56'd1000000000000;
  localparam logic [AMOUNT_W-1:0] LIMIT_100K = 56'd10000000000000;
  localparam logic [AMOUNT_W-1:0] LIMIT_1M   = 56'd100000000000000;

  localparam logic [WORD_W-1:0] POS_MAX = {1'b0, {(WORD_W-1){1'b1}}};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // Capture the trade and start the boundary division.
    logic emit_load;  // Load the output word from the current word index.
    logic roll;       // Open the next candle (first or boundary trade).
    logic first;      // The roll is the first trade.
    logic update;     // Fold the trade into the candle.
    logic word_inc;   // Advance to the next word.
  } ttca_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic started;
    logic past_close;
    logic word_last;
  } ttca_stat_t;

endpackage

// File: rtl/trade_tick_candle_aggregator_core.sv
// ----------------------------------------------------------------------------
// trade_tick_candle_aggregator_core
// Builds OHLCV candles from trades and sends each finished candle as 15 words.
// ----------------------------------------------------------------------------
// A trade runs through the boundary division, one quotient bit a cycle,
// and is then folded into the candle. A trade that closes a candle first sends
// the 15 words, one per cycle when taken, then opens the next candle.
// A new trade is taken only once the last one is through.
// Reset: synchronous; clears the candle, the interval returns to 60 seconds.
module trade_tick_candle_aggregator_core #(
  parameter int COUNT_BITS = 32,
  parameter int TIME_BITS  = 48
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [16:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic [47:0] trade_time_ms,
  input  logic [55:0] trade_price,
  input  logic [55:0] quote_amount,
  input  logic taker_sells,
  output logic out_valid,
  input  logic out_ready,
  output logic [3:0] word_index,
  output logic signed [63:0] word_value,
  output logic last_word
);
  import ttca_pkg::*;

  ttca_cmd_t  cmd;
  ttca_stat_t stat;

  assign cfg_ready = 1'b1;

  ttca_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .stat(stat)
  );

  ttca_datapath #(.COUNT_BITS(COUNT_BITS), .TIME_BITS(TIME_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_we(cfg_valid && cfg_ready), .cfg_data(cfg_data),
    .trade_time_ms(trade_time_ms), .trade_price(trade_price),
    .quote_amount(quote_amount), .taker_sells(taker_sells),
    .word_index(word_index), .word_value(word_value), .last_word(last_word)
  );
endmodule

// File: rtl/ttca_divider.sv
// ----------------------------------------------------------------------------
// ttca_divider
// Restoring divider, one quotient bit per cycle, for the boundary rounding.
// ----------------------------------------------------------------------------
module ttca_divider #(
  parameter int N_W = 48,
  parameter int D_W = 27
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [N_W-1:0] numer,
  input  logic [D_W-1:0] denom,
  output logic           done,
  output logic [D_W-1:0] rem,
  output logic           rem_nz
);
  localparam int CNT_W = $clog2(N_W + 1);

  logic [N_W-1:0] q;
  logic [D_W:0]   r;
  logic [D_W-1:0] d;
  logic [CNT_W-1:0] cnt;
  logic busy;
  logic [D_W:0] trial;

  assign trial = {r[D_W-1:0], q[N_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(N_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= numer;
      r <= '0;
      d <= denom;
    end else if (busy) begin
      if (trial >= {1'b0, d}) begin
        r <= trial - {1'b0, d};
        q <= {q[N_W-2:0], 1'b1};
      end else begin
        r <= trial;
        q <= {q[N_W-2:0], 1'b0};
      end
    end
  end

  assign rem    = r[D_W-1:0];
  assign rem_nz = (r != '0);
endmodule

// File: rtl/ttca_datapath.sv
// ----------------------------------------------------------------------------
// ttca_datapath
// Candle registers, boundary arithmetic, accumulators and output word.
// ----------------------------------------------------------------------------
module ttca_datapath #(
  parameter int COUNT_BITS = 32,
  parameter int TIME_BITS  = 48
) (
  input  logic clk,
  input  logic rst,
  input  ttca_pkg::ttca_cmd_t  cmd,
  output ttca_pkg::ttca_stat_t stat,
  input  logic                 cfg_we,
  input  logic [16:0]          cfg_data,
  input  logic [47:0]          trade_time_ms,
  input  logic [55:0]          trade_price,
  input  logic [55:0]          quote_amount,
  input  logic                 taker_sells,
  output logic [3:0]           word_index,
  output logic signed [63:0]   word_value,
  output logic                 last_word
);
  import ttca_pkg::*;

  localparam int IV_W = INTERVAL_W + 10;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
  localparam logic [63:0] CNT_MAX64 =
    (COUNT_BITS >= 64) ? POS_MAX : ((64'd1 << COUNT_BITS) - 64'd1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = COUNT_BITS'(CNT_MAX64);

  logic [INTERVAL_W-1:0] interval;
  logic [IV_W-1:0] iv_ms;
  logic [TIME_BITS-1:0] t_in, t_r;
  logic [PRICE_W-1:0] price_r;
  logic [AMOUNT_W-1:0] amount_r;
  logic sells_r;

  logic started, div_done, rem_nz;
  logic [IV_W-1:0] rem;
  logic [TIME_BITS-1:0] open_time, close_time;
  logic [PRICE_W-1:0] open_price, high_price, low_price;
  logic [63:0] buy_volume, sell_volume;
  logic [COUNT_BITS-1:0] buy_count, sell_count;
  logic signed [63:0] deltas [NUM_BUCKETS];
  logic [3:0] word_sel;

  logic [TIME_BITS:0] rnd_base, rnd_sum;
  logic [TIME_BITS-1:0] close_next;
  logic [2:0] bucket;
  logic [63:0] vol_sel, vol_sum;
  logic [COUNT_BITS-1:0] cnt_sel;
  logic signed [63:0] dsel, dq, dsum;

  // Input time saturates into the configured time width.
  always_comb begin
    if (TIME_BITS >= 48) t_in = TIME_BITS'(trade_time_ms);
    else if ((trade_time_ms >> TIME_BITS) != '0) t_in = TIME_MAX;
    else t_in = TIME_BITS'(trade_time_ms);
  end

  always_comb begin
    if (interval == '0) iv_ms = IV_W'(1000);
    else iv_ms = IV_W'(interval) * IV_W'(1000);
  end

  always_ff @(posedge clk) begin
    if (rst) interval <= INTERVAL_RESET;
    else if (cfg_we) interval <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_r      <= t_in;
      price_r  <= trade_price;
      amount_r <= quote_amount;
      sells_r  <= taker_sells;
    end
  end

  ttca_divider #(.N_W(TIME_BITS), .D_W(IV_W)) u_div (
    .clk(clk), .rst(rst), .start(cmd.load), .numer(t_in), .denom(iv_ms),
    .done(div_done), .rem(rem), .rem_nz(rem_nz)
  );

  // Rounded-up boundary: the time minus its remainder, plus one interval when
  // the remainder is nonzero, saturated to the time range.
  always_comb begin
    rnd_base = {1'b0, t_r} - (TIME_BITS+1)'(rem);
    rnd_sum  = rnd_base + (rem_nz ? (TIME_BITS+1)'(iv_ms) : '0);
    if (rnd_sum > {1'b0, TIME_MAX}) close_next = TIME_MAX;
    else close_next = rnd_sum[TIME_BITS-1:0];
  end

  always_comb begin
    if (amount_r <= LIMIT_1K) bucket = 3'd0;
    else if (amount_r <= LIMIT_10K) bucket = 3'd1;
    else if (amount_r <= LIMIT_100K) bucket = 3'd2;
    else if (amount_r <= LIMIT_1M) bucket = 3'd3;
    else bucket = 3'd4;
    vol_sel = sells_r ? sell_volume : buy_volume;
    vol_sum = vol_sel + 64'(amount_r);
    cnt_sel = sells_r ? sell_count : buy_count;
    dsel = deltas[bucket];
    dq   = sells_r ? -$signed(64'(amount_r)) : $signed(64'(amount_r));
    dsum = dsel + dq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      open_time <= '0;
      close_time <= '0;
      open_price <= '0;
      high_price <= '0;
      low_price <= '1;
      buy_volume <= '0;
      sell_volume <= '0;
      buy_count <= '0;
      sell_count <= '0;
      for (int i = 0; i < NUM_BUCKETS; i++) deltas[i] <= '0;
    end else if (cmd.roll) begin
      started <= 1'b1;
      if (cmd.first)
        open_time <= (close_next >= TIME_BITS'(iv_ms)) ?
                     close_next - TIME_BITS'(iv_ms) : '0;
      else open_time <= close_time;
      close_time <= close_next;
      open_price <= price_r;
      high_price <= '0;
      low_price <= '1;
      buy_volume <= '0;
      sell_volume <= '0;
      buy_count <= '0;
      sell_count <= '0;
      for (int i = 0; i < NUM_BUCKETS; i++) deltas[i] <= '0;
    end else if (cmd.update) begin
      if (price_r > high_price) high_price <= price_r;
      if (price_r < low_price) low_price <= price_r;
      if (sells_r) begin
        sell_volume <= vol_sum[63] ? POS_MAX : vol_sum;
        if (sell_count != CNT_MAX) sell_count <= sell_count + 1'b1;
      end else begin
        buy_volume <= vol_sum[63] ? POS_MAX : vol_sum;
        if (buy_count != CNT_MAX) buy_count <= buy_count + 1'b1;
      end
      // Sign overflow: operands agree in sign and the sum does not.
      if (!sells_r && !dsel[63] && dsum[63]) deltas[bucket] <= POS_MAX;
      else if (sells_r && dsel[63] && !dsum[63] && dq != 0)
        deltas[bucket] <= {1'b1, 63'd0};
      else deltas[bucket] <= dsum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) word_sel <= '0;
    else if (cmd.load) word_sel <= '0;
    else if (cmd.word_inc) word_sel <= word_sel + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      word_index <= word_sel;
      last_word  <= (word_sel == WORD_LAST);
      case (word_sel)
        4'd0:  word_value <= 64'(open_time);
        4'd1:  word_value <= 64'(close_time);
        4'd2:  word_value <= 64'(open_price);
        4'd3:  word_value <= 64'(high_price);
        4'd4:  word_value <= 64'(low_price);
        4'd5:  word_value <= 64'(price_r);
        4'd6:  word_value <= buy_volume;
        4'd7:  word_value <= sell_volume;
        4'd8:  word_value <= 64'(buy_count);
        4'd9:  word_value <= 64'(sell_count);
        4'd10: word_value <= deltas[0];
        4'd11: word_value <= deltas[1];
        4'd12: word_value <= deltas[2];
        4'd13: word_value <= deltas[3];
        default: word_value <= deltas[4];
      endcase
    end
  end

  assign stat.div_done   = div_done;
  assign stat.started    = started;
  assign stat.past_close = (t_r > close_time);
  assign stat.word_last  = (word_sel == WORD_LAST);
endmodule

// File: rtl/ttca_ctrl.sv
// ----------------------------------------------------------------------------
// ttca_ctrl
// Sequencer: accept, divide, emit words, roll the candle, fold the trade.
// ----------------------------------------------------------------------------
module ttca_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output ttca_pkg::ttca_cmd_t  cmd,
  input  ttca_pkg::ttca_stat_t stat
);
  import ttca_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DIV    = 6'b000010,
    S_DECIDE = 6'b000100,
    S_SHOW   = 6'b001000,
    S_ROLL   = 6'b010000,
    S_UPDATE = 6'b100000
  } state_t;

  state_t state, state_next;
  logic shown_last;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: if (stat.div_done) state_next = S_DECIDE;
      S_DECIDE: begin
        if (!stat.started) begin
          cmd.roll = 1'b1;
          cmd.first = 1'b1;
          state_next = S_UPDATE;
        end else if (stat.past_close) begin
          cmd.emit_load = 1'b1;
          cmd.word_inc = 1'b1;
          state_next = S_SHOW;
        end else begin
          state_next = S_UPDATE;
        end
      end
      S_SHOW: begin
        out_valid = 1'b1;
        if (out_ready) begin
          // The word on the output is the last one of the candle.
          if (shown_last) state_next = S_ROLL;
          else begin
            cmd.emit_load = 1'b1;
            cmd.word_inc = 1'b1;
          end
        end
      end
      S_ROLL: begin
        cmd.roll = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) shown_last <= 1'b0;
    else if (cmd.emit_load) shown_last <= stat.word_last;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  a_show_only: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_SHOW) else $error("word shown outside show state");
  a_roll_update: assert property (@(posedge clk) disable iff (rst)
    state == S_ROLL |=> state == S_UPDATE) else $error("roll not followed by update");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("accept while busy");
endmodule
